// ===== src/first_fit_owner_allocator_top_defines.svh =====
// assertion macros for the first-fit owner allocator
`ifndef FIRST_FIT_OWNER_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_OWNER_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffa assertion failed");
// next-cycle implication
`define FFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffa assertion failed");
`else
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

    localparam int OWNER_W = 10;
    localparam int SIZE_W  = 11;
    localparam int START_W = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SIZE_W-1:0]  request_size;
        logic [OWNER_W-1:0] owner_id;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_unit;
        logic [SIZE_W-1:0]  freed_units;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/ffa_req_if.sv =====
`default_nettype none

interface ffa_req_if
    import ffa_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ffa_rsp_if.sv =====
`default_nettype none

interface ffa_rsp_if
    import ffa_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ffa_owner_ram.sv =====
`default_nettype none

module ffa_owner_ram
    import ffa_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [OWNER_W-1:0] rd_data,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [OWNER_W-1:0] wr_data
);

    logic [OWNER_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/first_fit_owner_allocator_top.sv =====
// channel  | dir | payload                                    | transfer when
// ---------+-----+--------------------------------------------+-------------------
// req      | in  | operation, request_size, owner_id          | valid && ready
// rsp      | out | granted, start_unit, freed_units           | valid && ready
// cfg      | in  | pool_size (cfg_data)                       | cfg_we high
//
// one request at a time; the owner table is walked one unit per cycle through
// the read port of a single-port-read/single-port-write memory
// allocate: a first-fit scan of the units in use, then a fill of request_size units,
// then the result is loaded; free: a scan of all POOL_UNITS units, then the result
// after reset a clearing pass writes zero to every unit, with req.ready
// low (cfg writes still taken)
// a stalled rsp holds the block in its result state; a new req is taken
// while an earlier result still waits in the output register
`default_nettype none

`include "first_fit_owner_allocator_top_defines.svh"

module first_fit_owner_allocator_top
    import ffa_pkg::*;
#(
    parameter int POOL_UNITS = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ffa_req_if.sink                req,
    ffa_rsp_if.source              rsp,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    // unit index width, count width (holds POOL_UNITS itself), wide scratch width
    localparam int IDX_W = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
    localparam int CNT_W = $clog2(POOL_UNITS + 1);
    localparam int WW    = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [SIZE_W-1:0]  pool_size_reg;
    logic               op_reg, op_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   eval_addr_reg, eval_addr_next;
    logic [SIZE_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   fill_addr_reg, fill_addr_next;
    logic [SIZE_W-1:0]  fill_left_reg, fill_left_next;
    rsp_t               res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg, rsp_data_next;

    // memory port
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [OWNER_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [OWNER_W-1:0] wr_data;

    // scratch
    logic [WW-1:0]      pool_w;
    logic [WW-1:0]      units_w;
    logic [WW-1:0]      limit_w;
    logic [WW-1:0]      first_w;
    logic [WW-1:0]      count_w;
    logic [SIZE_W-1:0]  run_inc;
    logic               issue;
    logic               found;

    ffa_owner_ram #(
        .DEPTH  (POOL_UNITS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // units in use, saturated to the table depth
    assign pool_w  = WW'(pool_size_reg);
    assign units_w = WW'(POOL_UNITS);
    assign limit_w = (pool_w > units_w) ? units_w : pool_w;

    assign run_inc = run_reg + 1'b1;
    assign first_w = WW'(eval_addr_reg) + WW'(1) - WW'(size_reg);
    assign count_w = WW'(count_reg);
    assign issue   = (issue_reg < end_reg);
    // a free unit that completes a run of the requested length
    assign found   = pend_reg && (op_reg == OP_ALLOC) && (rd_data == '0)
                     && (run_inc == size_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        owner_next     = owner_reg;
        end_next       = end_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        eval_addr_next = eval_addr_reg;
        run_next       = run_reg;
        count_next     = count_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = eval_addr_reg;
        wr_data        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(POOL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.data.operation;
                    size_next  = req.data.request_size;
                    owner_next = req.data.owner_id;
                    end_next   = (req.data.operation == OP_FREE) ? CNT_W'(POOL_UNITS)
                                                                 : limit_w[CNT_W-1:0];
                    issue_next = '0;
                    run_next   = '0;
                    count_next = '0;
                    res_next   = '0;
                    // owner zero, or an empty allocate, never touches the table
                    if ((req.data.owner_id == '0) ||
                        ((req.data.operation == OP_ALLOC) && (req.data.request_size == '0)))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    fill_addr_next      = first_w[IDX_W-1:0];
                    fill_left_next      = size_reg;
                    res_next.start_unit = first_w[START_W-1:0];
                    state_next          = S_FILL;
                end
                else
                begin
                    // issue the next read while the previous unit is checked
                    if (issue)
                    begin
                        rd_en          = 1'b1;
                        issue_next     = issue_reg + 1'b1;
                        eval_addr_next = issue_reg[IDX_W-1:0];
                        pend_next      = 1'b1;
                    end
                    if (pend_reg)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            run_next = (rd_data == '0) ? run_inc : '0;
                        end
                        else if (rd_data == owner_reg)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (!pend_reg && !issue)
                    begin
                        res_next.granted     = 1'b0;
                        res_next.start_unit  = '0;
                        res_next.freed_units = (op_reg == OP_FREE) ? count_w[SIZE_W-1:0]
                                                                   : '0;
                        state_next           = S_DONE;
                    end
                end
            end

            S_FILL:
            begin
                wr_en          = 1'b1;
                wr_addr        = fill_addr_reg;
                wr_data        = owner_reg;
                fill_addr_next = fill_addr_reg + 1'b1;
                fill_left_next = fill_left_reg - 1'b1;
                if (fill_left_reg == SIZE_W'(1))
                begin
                    res_next.granted     = 1'b1;
                    res_next.freed_units = '0;
                    state_next           = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            pool_size_reg <= SIZE_W'(1024);
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        owner_reg     <= owner_next;
        end_reg       <= end_next;
        issue_reg     <= issue_next;
        eval_addr_reg <= eval_addr_next;
        run_reg       <= run_next;
        count_reg     <= count_next;
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        res_reg       <= res_next;
        rsp_data_reg  <= rsp_data_next;
    end

    // a granted block reports no freed units
    `FFA_ASSERT_IMP(a_grant_no_free, clk, rst_n,
                    rsp_valid_reg && rsp_data_reg.granted, rsp_data_reg.freed_units == '0)
    // a refused request reports start unit zero
    `FFA_ASSERT_IMP(a_refuse_start_zero, clk, rst_n,
                    rsp_valid_reg && !rsp_data_reg.granted, rsp_data_reg.start_unit == '0)
    // a fill never runs past the units in use
    `FFA_ASSERT_IMP(a_fill_in_range, clk, rst_n,
                    state_reg == S_FILL, CNT_W'(fill_addr_reg) < end_reg)
    // a new result is loaded only from the result state
    `FFA_ASSERT_IMP(a_result_source, clk, rst_n,
                    $rose(rsp_valid_reg), $past(state_reg) == S_DONE)
    // no read is in flight once the scan has ended
    `FFA_ASSERT_NXT(a_no_stray_read, clk, rst_n, state_reg != S_SCAN, !pend_reg)

endmodule

`default_nettype wire
